// ===== rtl/asde_pkg.sv =====
// ----------------------------------------------------------------------------
// asde_pkg: shared types and constants for the stick deadzone block
// Widths of the iterative root and divide datapaths, event codes, and the
// result records that the arithmetic units hand back to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package asde_pkg;

   localparam int RAD_W  = 32;           // radicand: S << 16
   localparam int ROOT_W = 16;           // floor(sqrt(S << 16))
   localparam int NUM_W  = 47;           // (mag * diff) << 22
   localparam int DEN_W  = 33;           // rq * (65536 - dz)
   localparam int DVS_W  = DEN_W + 15;   // divisor aligned to the top quotient bit
   localparam int QUO_W  = 16;
   localparam int ITER_W = 4;            // counts 16 steps in both units

   localparam logic [1:0]  ACT_DOWN = 2'd0;
   localparam logic [1:0]  ACT_MOVE = 2'd1;
   localparam logic [1:0]  ACT_UP   = 2'd2;
   localparam logic [15:0] DZ_RESET = 16'd10486;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic             done;
      logic             sat;    // quotient is 65536 or more
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/asde_sqrt.sv =====
// ----------------------------------------------------------------------------
// asde_sqrt: iterative integer square root
// Digit-by-digit root of a 32-bit radicand, one result bit per cycle,
// sixteen steps, then a one-cycle done.
// ----------------------------------------------------------------------------
`default_nettype none

module asde_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [asde_pkg::RAD_W-1:0] radicand,
   output asde_pkg::sqrt_rsp_type          rsp
);
   import asde_pkg::*;

   logic [RAD_W-1:0]  v_ff, v_in;
   logic [RAD_W-1:0]  res_ff, res_in;
   logic [RAD_W-1:0]  bit_ff, bit_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [RAD_W-1:0]  trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + ITER_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/asde_div.sv =====
// ----------------------------------------------------------------------------
// asde_div: iterative restoring divider
// Flags quotients of 65536 and up at start, then forms sixteen quotient
// bits, one compare and subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asde_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [asde_pkg::NUM_W-1:0] num,
   input  wire logic [asde_pkg::DEN_W-1:0] den,
   output asde_pkg::div_rsp_type           rsp
);
   import asde_pkg::*;

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              sat_ff, sat_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   assign fits = rem_ff >= dvs_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DVS_W'(num);
         dvs_in  = {den, 15'd0};
         quo_in  = '0;
         sat_in  = (DVS_W + 1)'(num) >= {den, 16'd0};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + ITER_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/analog_stick_deadzone_events_top.sv =====
// ----------------------------------------------------------------------------
// analog_stick_deadzone_events_top: radial scaled deadzone with stick events
// Centers a raw 8-bit X/Y stick beat, applies a radial deadzone with length
// rescaling, emits signed Q2.14 output and a DOWN / MOVE / UP event per stick.
// ----------------------------------------------------------------------------
`default_nettype none

// One request beat in gives one response beat out. The block works on one
// beat at a time: req_ready is high only while the sequencer is idle, and an
// item is paced by the sixteen-step iterative square root and two passes of
// the sixteen-step shared divider (one per axis); a sample inside the
// deadzone skips the divider. A finished response sits in an output
// register, so the next request can be taken while it waits for rsp_ready;
// a response still waiting when the next sample finishes holds the
// sequencer until it is taken. The deadzone register (Q0.16, reset 10486)
// is written with csr_we / csr_wdata and must only change while no request
// is in flight. Each stick keeps two activity bits of history, cleared by
// reset; a sample is active when either output axis is nonzero.

module analog_stick_deadzone_events_top (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_stick_id,
   input  wire logic [7:0]         req_raw_x,
   input  wire logic [7:0]         req_raw_y,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_stick_out,
   output logic signed [15:0]      rsp_out_x,
   output logic signed [15:0]      rsp_out_y,
   output logic [1:0]              rsp_action,
   // deadzone register
   input  wire logic               csr_we,
   input  wire logic [15:0]        csr_wdata
);
   import asde_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;   // wait for a request beat
   localparam logic [2:0] ST_SQ   = 3'd1;   // square and sum, launch root
   localparam logic [2:0] ST_ROOT = 3'd2;   // wait for root
   localparam logic [2:0] ST_CHK  = 3'd3;   // deadzone test, form divisor
   localparam logic [2:0] ST_NUM  = 3'd4;   // form dividend, launch divide
   localparam logic [2:0] ST_DIV  = 3'd5;   // wait for quotient
   localparam logic [2:0] ST_FIN  = 3'd6;   // event decode, load response

   logic [2:0]        state_ff, state_in;
   logic [15:0]       dz_ff, dz_in;

   // captured sample
   logic              id_ff, id_in;
   logic [7:0]        mag_x_ff, mag_x_in;
   logic [7:0]        mag_y_ff, mag_y_in;
   logic              neg_x_ff, neg_x_in;
   logic              neg_y_ff, neg_y_in;

   // working values
   logic [ROOT_W-1:0] rq_ff, rq_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [16:0]       diff_ff, diff_in;
   logic              axis_ff, axis_in;
   logic [15:0]       ox_ff, ox_in;
   logic [15:0]       oy_ff, oy_in;

   // per-stick history: [stick][0] previous sample, [stick][1] one before
   logic [1:0][1:0]   hist_ff, hist_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_id_ff, rsp_id_in;
   logic [15:0]       rsp_x_ff, rsp_x_in;
   logic [15:0]       rsp_y_ff, rsp_y_in;
   logic [1:0]        rsp_act_ff, rsp_act_in;

   // arithmetic unit hookup
   logic              sqrt_start;
   logic [RAD_W-1:0]  radicand;
   sqrt_rsp_type      sqrt_rsp;
   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   div_rsp_type       div_rsp;

   // combinational helpers
   logic [15:0]       sq_sum;
   logic              in_zone;
   logic [7:0]        mag_sel;
   logic [24:0]       num_prod;
   logic              neg_sel;
   logic [15:0]       axis_val;
   logic              cur_act;
   logic              p1;
   logic              p2;
   logic [1:0]        act_code;
   logic              out_free;

   // centered axis: raw - 128 as sign and magnitude
   function automatic logic [7:0] center_mag(input logic [7:0] raw);
      center_mag = raw[7] ? {1'b0, raw[6:0]} : 8'd128 - raw;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // S = cx^2 + cy^2 peaks at 32768, so 16 bits hold it
   assign sq_sum     = 16'(mag_x_ff * mag_x_ff) + 16'(mag_y_ff * mag_y_ff);
   assign radicand   = {sq_sum, 16'd0};
   assign sqrt_start = (state_ff == ST_SQ);

   assign in_zone = (rq_ff == '0) || ({rq_ff, 1'b0} < {1'b0, dz_ff});

   assign mag_sel   = axis_ff ? mag_y_ff : mag_x_ff;
   assign num_prod  = 25'(mag_sel * diff_ff);
   assign div_num   = {num_prod, 22'd0};
   assign div_start = (state_ff == ST_NUM);

   // saturate quotient and apply the sign of the centered axis
   assign neg_sel = axis_ff ? neg_y_ff : neg_x_ff;
   always_comb begin
      if (neg_sel) begin
         if (div_rsp.sat || (div_rsp.quo > 16'd32768)) begin
            axis_val = 16'h8000;
         end else begin
            axis_val = 16'd0 - div_rsp.quo;
         end
      end else begin
         if (div_rsp.sat || (div_rsp.quo > 16'd32767)) begin
            axis_val = 16'h7FFF;
         end else begin
            axis_val = div_rsp.quo;
         end
      end
   end

   // event decode from this sample and the stick's two previous ones
   assign cur_act = (ox_ff != '0) || (oy_ff != '0);
   assign p1      = hist_ff[id_ff][0];
   assign p2      = hist_ff[id_ff][1];
   always_comb begin
      if (!cur_act && !p1 && p2) begin
         act_code = ACT_UP;
      end else if (cur_act && !p1 && !p2) begin
         act_code = ACT_DOWN;
      end else begin
         act_code = ACT_MOVE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dz_in        = csr_we ? csr_wdata : dz_ff;
      id_in        = id_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      rq_in        = rq_ff;
      den_in       = den_ff;
      diff_in      = diff_ff;
      axis_in      = axis_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      hist_in      = hist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_act_in   = rsp_act_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in    = req_stick_id;
               mag_x_in = center_mag(req_raw_x);
               mag_y_in = center_mag(req_raw_y);
               neg_x_in = !req_raw_x[7];
               neg_y_in = !req_raw_y[7];
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_rsp.done) begin
               rq_in    = sqrt_rsp.root;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            // zero vector or inside the deadzone: no divide at all
            if (in_zone) begin
               ox_in    = '0;
               oy_in    = '0;
               state_in = ST_FIN;
            end else begin
               den_in   = DEN_W'(rq_ff * (17'h10000 - {1'b0, dz_ff}));
               diff_in  = {rq_ff, 1'b0} - {1'b0, dz_ff};
               axis_in  = 1'b0;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (axis_ff) begin
                  oy_in    = axis_val;
                  state_in = ST_FIN;
               end else begin
                  ox_in    = axis_val;
                  axis_in  = 1'b1;
                  state_in = ST_NUM;
               end
            end
         end
         ST_FIN: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_id_in         = id_ff;
               rsp_x_in          = ox_ff;
               rsp_y_in          = oy_ff;
               rsp_act_in        = act_code;
               hist_in[id_ff][1] = p1;
               hist_in[id_ff][0] = cur_act;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dz_ff        <= DZ_RESET;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dz_ff        <= dz_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff      <= id_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      rq_ff      <= rq_in;
      den_ff     <= den_in;
      diff_ff    <= diff_in;
      axis_ff    <= axis_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_act_ff <= rsp_act_in;
   end

   asde_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .rsp      (sqrt_rsp)
   );

   // shared by both axes, one pass each
   asde_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .rsp   (div_rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_stick_out = rsp_id_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_action    = rsp_act_ff;

   // a taken request beat closes the input until the sequencer is done
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a sample was in flight");

   // an UP event always reports a resting stick
   a_up_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_UP) |-> (rsp_out_x == '0 && rsp_out_y == '0))
      else $error("UP event with nonzero output");

   // a DOWN event always reports a deflected stick
   a_down_is_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_DOWN) |-> (rsp_out_x != '0 || rsp_out_y != '0))
      else $error("DOWN event with zero output");

   // both arithmetic units report done only while the sequencer waits on them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      (sqrt_rsp.done || div_rsp.done) |-> (state_ff == ST_ROOT || state_ff == ST_DIV))
      else $error("arithmetic unit finished outside its wait state");

endmodule

`default_nettype wire
